// ----- hw/rtl/cbs_pkg.sv -----
// Package for the chained byte scrambler: word kind codes, key table,
// bit permutation tables and the small modulo helpers. No dependencies.
package cbs_pkg;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_SCRAMBLE   = 2'd1,
    KIND_DESCRAMBLE = 2'd2
  } kind_e;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] perm_sel_t;
  typedef logic [3:0] key_idx_t;

  localparam int unsigned KeyDepth = 13;
  localparam int unsigned PermCount = 7;

  // Rows past the key count are never selected.
  localparam byte_t KEY_TABLE [16] = '{
    8'h26, 8'hFF, 8'hE8, 8'hEF, 8'h42, 8'hD6, 8'h01,
    8'h54, 8'h14, 8'hA3, 8'h80, 8'hFD, 8'h6E,
    8'h00, 8'h00, 8'h00
  };

  // PERM_DEST[s][k]: scrambled bit position that receives source bit k.
  // The last row is an identity and is never selected.
  localparam logic [2:0] PERM_DEST [8][8] = '{
    '{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7},
    '{3'd3, 3'd0, 3'd2, 3'd6, 3'd5, 3'd4, 3'd7, 3'd1},
    '{3'd6, 3'd5, 3'd0, 3'd1, 3'd3, 3'd7, 3'd2, 3'd4},
    '{3'd1, 3'd3, 3'd7, 3'd4, 3'd0, 3'd2, 3'd5, 3'd6},
    '{3'd7, 3'd2, 3'd5, 3'd0, 3'd6, 3'd1, 3'd4, 3'd3},
    '{3'd5, 3'd6, 3'd4, 3'd3, 3'd7, 3'd0, 3'd1, 3'd2},
    '{3'd2, 3'd1, 3'd6, 3'd7, 3'd4, 3'd3, 3'd0, 3'd5},
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7}
  };

  // Fold 3-bit groups (8 = 1 mod 7), then one compare and subtract.
  function automatic perm_sel_t mod7(input byte_t v);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = {2'b00, v[2:0]} + {2'b00, v[5:3]} + {3'b000, v[7:6]};
    s2 = {1'b0, s1[2:0]} + {2'b00, s1[4:3]};
    if (s2 >= 4'd7) s2 = s2 - 4'd7;
    return s2[2:0];
  endfunction

  // 16 = 3 mod 13: reduce to 3*hi + lo (at most 60), then subtract stepwise.
  function automatic key_idx_t mod13(input byte_t v);
    logic [5:0] x;
    x = {2'b00, v[3:0]} + {2'b00, v[7:4]} + {1'b0, v[7:4], 1'b0};
    if (x >= 6'd52) x = x - 6'd52;
    if (x >= 6'd26) x = x - 6'd26;
    if (x >= 6'd13) x = x - 6'd13;
    return x[3:0];
  endfunction

  function automatic byte_t permute_fwd(input byte_t v, input perm_sel_t sel);
    byte_t r;
    r = '0;
    for (int k = 0; k < 8; k++) r[PERM_DEST[sel][k]] = v[k];
    return r;
  endfunction

  function automatic byte_t permute_inv(input byte_t c, input perm_sel_t sel);
    byte_t r;
    r = '0;
    for (int k = 0; k < 8; k++) r[k] = c[PERM_DEST[sel][k]];
    return r;
  endfunction

endpackage

// ----- hw/rtl/cbs_xform.sv -----
// Single-pass byte transform: key XOR, chain XOR and bit permutation.
// Depends on cbs_pkg for tables and helper functions.
module cbs_xform (
  input  logic [1:0]     kind_i,
  input  cbs_pkg::byte_t data_i,
  input  cbs_pkg::byte_t chain_i,
  output cbs_pkg::byte_t result_o,
  output cbs_pkg::byte_t chain_o
);
  import cbs_pkg::*;

  byte_t     key;
  perm_sel_t sel;

  assign key = KEY_TABLE[mod13(chain_i)];
  assign sel = mod7(chain_i);

  always_comb begin
    result_o = data_i;
    chain_o  = chain_i;
    case (kind_i)
      KIND_HEADER: begin
        chain_o = data_i;
      end
      KIND_SCRAMBLE: begin
        result_o = permute_fwd(data_i ^ chain_i ^ key, sel);
        chain_o  = result_o;
      end
      KIND_DESCRAMBLE: begin
        result_o = permute_inv(data_i, sel) ^ key ^ chain_i;
        chain_o  = data_i;
      end
      default: begin
        // unused kind code: pass the word, hold the chain
        result_o = data_i;
        chain_o  = chain_i;
      end
    endcase
  end

endmodule

// ----- hw/rtl/chained_byte_scrambler.sv -----
// Top level of the chained byte scrambler: input register, transform,
// result register and chain register. Depends on cbs_pkg and cbs_xform.
//
// Streams one word per cycle with valid/ready on both sides. Each word sits
// in the input register, where the transform reads the chain register, and
// then moves to the result register, which drives output valid. A new word
// is accepted every cycle as long as the output side takes words; input
// ready drops only when both registers hold words and the output is not
// taken. The chain register updates in the same cycle a word moves to the
// result register, so the next word already sees the updated chain. Header
// words pass unchanged and load the chain; scramble words load the chain
// with the scrambled output; descramble words load it with the incoming
// ciphertext. last_byte travels alongside each word as last_o and does not
// touch the chain. The unused kind code passes the word and holds the
// chain. After reset the chain is zero.
module chained_byte_scrambler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     kind_i,
  input  cbs_pkg::byte_t data_byte_i,
  input  logic           last_byte_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cbs_pkg::byte_t out_byte_o,
  output logic           last_o
);
  import cbs_pkg::*;

  // input stage
  logic       s1_valid_q;
  logic [1:0] s1_kind_q;
  byte_t      s1_data_q;
  logic       s1_last_q;

  // result stage
  logic  out_valid_q;
  byte_t out_byte_q;
  logic  last_q;

  byte_t chain_q, chain_d;
  byte_t result;

  logic out_free;
  logic s1_move;
  logic in_take;

  // Result register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  cbs_xform u_xform (
    .kind_i   (s1_kind_q),
    .data_i   (s1_data_q),
    .chain_i  (chain_q),
    .result_o (result),
    .chain_o  (chain_d)
  );

  // Control state: valid flags and chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= '0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (out_free)   out_valid_q <= s1_valid_q;
      // advance the chain only when the word leaves the input stage
      if (s1_move)    chain_q <= chain_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= kind_i;
      s1_data_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (s1_move) begin
      out_byte_q <= result;
      last_q     <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  // Backpressure only when both stages hold words and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // Header and descramble words load the chain with the incoming byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && (s1_kind_q == KIND_HEADER || s1_kind_q == KIND_DESCRAMBLE))
      |=> chain_q == $past(s1_data_q))
    else $error("chain not loaded from incoming byte");

  // Header words pass through unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_kind_q == KIND_HEADER) |=> out_byte_o == $past(s1_data_q))
    else $error("header word altered");

  // Scramble words load the chain with their own output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_kind_q == KIND_SCRAMBLE) |=> chain_q == out_byte_o)
    else $error("chain differs from scrambled output");

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_byte_o)))
    else $error("stalled result word changed");

endmodule
